// ===== rtl/core/wdpt_pkg.sv =====
// Shared types and constants for the write and dirty-page tracker.
package wdpt_pkg;

    // Bits in one bitmap word of either map.
    localparam int unsigned MAP_WORD_BITS = 32;

    // Action codes carried on the action port.
    typedef enum logic [2:0] {
        ACT_WRITE       = 3'd0,
        ACT_CHECK       = 3'd1,
        ACT_CHECK_CLEAN = 3'd2,
        ACT_CLEAN       = 3'd3,
        ACT_RUN         = 3'd4
    } action_t;

    // Result of evaluating one bitmap word against a bit window.
    typedef struct packed {
        logic [MAP_WORD_BITS-1:0] mask;      // window bits lo..hi
        logic                     any;       // some set bit inside the window
        logic                     all_ones;  // no clear bit inside the window
        logic [4:0]               zero_pos;  // lowest clear bit inside the window
    } eval_t;

endpackage

// ===== rtl/core/wdpt_bit_eval.sv =====
// Window mask, set test and first-clear-bit search over one bitmap word.
module wdpt_bit_eval
(
    input  logic [wdpt_pkg::MAP_WORD_BITS-1:0] data,
    input  logic [4:0]                         lo,
    input  logic [4:0]                         hi,
    output wdpt_pkg::eval_t                    res
);

    logic [wdpt_pkg::MAP_WORD_BITS-1:0] mask;
    logic [wdpt_pkg::MAP_WORD_BITS-1:0] zeros;
    logic [4:0]                         pos;

    assign mask  = ({wdpt_pkg::MAP_WORD_BITS{1'b1}} << lo)
                 & ({wdpt_pkg::MAP_WORD_BITS{1'b1}} >> (5'd31 - hi));
    assign zeros = ~data & mask;

    // Lowest clear bit wins: scan from the top down.
    always_comb
    begin
        pos = '0;
        for (int i = wdpt_pkg::MAP_WORD_BITS - 1; i >= 0; i--)
        begin
            if (zeros[i])
            begin
                pos = 5'(i);
            end
        end
    end

    assign res.mask     = mask;
    assign res.any      = |(data & mask);
    assign res.all_ones = (zeros == '0);
    assign res.zero_pos = pos;

endmodule

// ===== rtl/core/write_and_dirty_page_tracker_unit.sv =====
// Top level of the write and dirty-page tracker: sequencer and both bitmaps.
//
//   channel   signals                              direction  handshake
//   -------   ----------------------------------   ---------  --------------------------
//   command   start, action, address, length_bytes in         taken when start & !busy
//   result    done, dirty, run_bytes               out        valid for the one done cycle
//   status    busy                                 out        high while a word is in work
//
// Steps: a setup state, then a read and an evaluate state per bitmap word visited;
// done rises in the cycle after the last evaluate, or after setup if none is visited.
// A word write visits one word of each map; a range check visits each dirty-map word
// scanned, and a clean pass visits them again; a run visits each written-map word
// scanned. The single read port of each bitmap and the shared window evaluator set
// this order. Reset: a clearing pass zeroes both bitmaps; busy stays high.
// The receiver cannot stall: each result is shown for exactly one cycle.
module write_and_dirty_page_tracker_unit
#(
    parameter int unsigned MEM_BYTES  = 1048576,
    parameter int unsigned PAGE_BYTES = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  action,
    input  logic [19:0] address,
    input  logic [20:0] length_bytes,
    output logic        done,
    output logic        dirty,
    output logic [20:0] run_bytes
);

    // Written-word map: one bit per 32-bit word, 32 words (128 bytes) per map word.
    localparam int unsigned WMAP_DEPTH  = MEM_BYTES / 128;
    localparam int unsigned WWW         = $clog2(WMAP_DEPTH);
    // Dirty-page map: one bit per page.
    localparam int unsigned PSH         = $clog2(PAGE_BYTES);
    localparam int unsigned PAGES_TOTAL = MEM_BYTES / PAGE_BYTES;
    localparam int unsigned PMAP_DEPTH  = (PAGES_TOTAL + 31) / 32;
    localparam int unsigned PWW         = (PMAP_DEPTH > 1) ? $clog2(PMAP_DEPTH) : 1;
    localparam int unsigned PGW         = $clog2(PAGES_TOTAL);
    localparam int unsigned PIW         = (PGW > 5) ? PGW : 5;
    // Run total: wide enough for the whole memory, at least the port width.
    localparam int unsigned RUNW        = $clog2(MEM_BYTES) + 1;
    localparam int unsigned TW          = (RUNW > 21) ? RUNW : 21;

    localparam int unsigned MW = wdpt_pkg::MAP_WORD_BITS;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_RD,
        S_EV
    } state_t;

    state_t              state_reg,  state_next;
    wdpt_pkg::action_t   act_reg,    act_next;
    logic [19:0]         addr_reg,   addr_next;
    logic [20:0]         len_reg,    len_next;
    logic [PIW-1:0]      first_reg,  first_next;
    logic [PIW-1:0]      last_reg,   last_next;
    logic [PWW-1:0]      pcur_reg,   pcur_next;
    logic [WWW:0]        cur_reg,    cur_next;
    logic [4:0]          bit_reg,    bit_next;
    logic [TW-1:0]       total_reg,  total_next;
    logic                clean_reg,  clean_next;
    logic                dirty_reg,  dirty_next;
    logic                done_reg,   done_next;

    // Bitmaps and their registered read data.
    logic [MW-1:0]       wmap_mem [WMAP_DEPTH];
    logic [MW-1:0]       pmap_mem [PMAP_DEPTH];
    logic [MW-1:0]       wmap_q;
    logic [MW-1:0]       pmap_q;
    logic                wmap_we;
    logic                pmap_we;
    logic [MW-1:0]       wmap_wdata;
    logic [MW-1:0]       pmap_wdata;
    logic [WWW-1:0]      wmap_addr;
    logic [PWW-1:0]      pmap_addr;

    // Setup decode of the held command.
    logic                in_mem;
    logic [21:0]         end_byte;
    logic [31:0]         last_raw;
    logic [PIW-1:0]      first_page;
    logic [PIW-1:0]      last_page;
    logic [WWW:0]        word_row;

    // Shared window evaluator.
    logic [MW-1:0]       ev_data;
    logic [4:0]          ev_lo;
    logic [4:0]          ev_hi;
    wdpt_pkg::eval_t     ev;
    logic [PWW-1:0]      first_row;
    logic [PWW-1:0]      last_row;
    logic [5:0]          run_span;

    assign in_mem     = (32'(addr_reg) < 32'(MEM_BYTES));
    assign end_byte   = 22'(addr_reg) + 22'(len_reg) - 22'd1;
    assign last_raw   = 32'(end_byte) >> PSH;
    assign first_page = PIW'(32'(addr_reg) >> PSH);
    // Clip a range that runs past the end of memory at the last page.
    assign last_page  = (last_raw > 32'(PAGES_TOTAL - 1)) ? PIW'(PAGES_TOTAL - 1)
                                                         : PIW'(last_raw);
    assign word_row   = (WWW+1)'(32'(addr_reg) >> 7);

    assign first_row  = PWW'(first_reg >> 5);
    assign last_row   = PWW'(last_reg >> 5);

    // Runs look at the written map from the current bit upward; ranges look at the
    // dirty map between the first and last page bits of the current row.
    always_comb
    begin
        if (act_reg == wdpt_pkg::ACT_RUN)
        begin
            ev_data = wmap_q;
            ev_lo   = bit_reg;
            ev_hi   = 5'd31;
        end
        else
        begin
            ev_data = pmap_q;
            ev_lo   = (pcur_reg == first_row) ? first_reg[4:0] : 5'd0;
            ev_hi   = (pcur_reg == last_row)  ? last_reg[4:0]  : 5'd31;
        end
    end

    wdpt_bit_eval u_eval
    (
        .data (ev_data),
        .lo   (ev_lo),
        .hi   (ev_hi),
        .res  (ev)
    );

    // Words added by this row: the rest of the row when all set, else up to the gap.
    assign run_span = ev.all_ones ? (6'd32 - 6'(bit_reg)) : (6'(ev.zero_pos) - 6'(bit_reg));

    assign wmap_addr = cur_reg[WWW-1:0];
    assign pmap_addr = (state_reg == S_CLEAR) ? cur_reg[PWW-1:0] : pcur_reg;

    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        addr_next  = addr_reg;
        len_next   = len_reg;
        first_next = first_reg;
        last_next  = last_reg;
        pcur_next  = pcur_reg;
        cur_next   = cur_reg;
        bit_next   = bit_reg;
        total_next = total_reg;
        clean_next = clean_reg;
        dirty_next = dirty_reg;
        done_next  = 1'b0;
        wmap_we    = 1'b0;
        pmap_we    = 1'b0;
        wmap_wdata = '0;
        pmap_wdata = '0;

        case (state_reg)
            S_CLEAR:
            begin
                // Zero one written-map row per cycle, and one dirty-map row while rows remain.
                wmap_we = 1'b1;
                pmap_we = (cur_reg < (WWW+1)'(PMAP_DEPTH));
                cur_next = cur_reg + 1'b1;
                if (cur_reg == (WWW+1)'(WMAP_DEPTH - 1))
                begin
                    cur_next   = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    act_next   = wdpt_pkg::action_t'(action);
                    addr_next  = address;
                    len_next   = length_bytes;
                    state_next = S_SETUP;
                end
            end

            S_SETUP:
            begin
                dirty_next = 1'b0;
                total_next = '0;
                clean_next = 1'b0;
                case (act_reg)
                    wdpt_pkg::ACT_WRITE:
                    begin
                        cur_next   = word_row;
                        bit_next   = addr_reg[6:2];
                        first_next = first_page;
                        pcur_next  = PWW'(first_page >> 5);
                        state_next = in_mem ? S_RD : S_IDLE;
                        done_next  = !in_mem;
                    end
                    wdpt_pkg::ACT_CHECK, wdpt_pkg::ACT_CHECK_CLEAN, wdpt_pkg::ACT_CLEAN:
                    begin
                        first_next = first_page;
                        last_next  = last_page;
                        pcur_next  = PWW'(first_page >> 5);
                        clean_next = (act_reg == wdpt_pkg::ACT_CLEAN);
                        // Empty range or range starting past memory: report clean.
                        if (in_mem && (len_reg != '0))
                        begin
                            state_next = S_RD;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                            done_next  = 1'b1;
                        end
                    end
                    wdpt_pkg::ACT_RUN:
                    begin
                        cur_next   = word_row;
                        bit_next   = addr_reg[6:2];
                        state_next = in_mem ? S_RD : S_IDLE;
                        done_next  = !in_mem;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                    end
                endcase
            end

            S_RD:
            begin
                // Read data lands at the end of this cycle.
                state_next = S_EV;
            end

            S_EV:
            begin
                case (act_reg)
                    wdpt_pkg::ACT_WRITE:
                    begin
                        wmap_we    = 1'b1;
                        wmap_wdata = wmap_q | (MW'(1) << bit_reg);
                        pmap_we    = 1'b1;
                        pmap_wdata = pmap_q | (MW'(1) << first_reg[4:0]);
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                    end
                    wdpt_pkg::ACT_RUN:
                    begin
                        total_next = total_reg + TW'({run_span, 2'b00});
                        bit_next   = 5'd0;
                        cur_next   = cur_reg + 1'b1;
                        if (!ev.all_ones || (cur_reg == (WWW+1)'(WMAP_DEPTH - 1)))
                        begin
                            state_next = S_IDLE;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                    default:
                    begin
                        if (clean_reg)
                        begin
                            // Drop the dirty bits of the window, then advance.
                            pmap_we    = 1'b1;
                            pmap_wdata = pmap_q & ~ev.mask;
                            if (pcur_reg == last_row)
                            begin
                                dirty_next = (act_reg == wdpt_pkg::ACT_CHECK_CLEAN);
                                state_next = S_IDLE;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                pcur_next  = pcur_reg + 1'b1;
                                state_next = S_RD;
                            end
                        end
                        else if (ev.any)
                        begin
                            if (act_reg == wdpt_pkg::ACT_CHECK_CLEAN)
                            begin
                                // Found a dirty page: rewind for the clean pass.
                                clean_next = 1'b1;
                                pcur_next  = first_row;
                                state_next = S_RD;
                            end
                            else
                            begin
                                dirty_next = 1'b1;
                                state_next = S_IDLE;
                                done_next  = 1'b1;
                            end
                        end
                        else if (pcur_reg == last_row)
                        begin
                            state_next = S_IDLE;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            pcur_next  = pcur_reg + 1'b1;
                            state_next = S_RD;
                        end
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            act_reg   <= wdpt_pkg::ACT_WRITE;
            addr_reg  <= '0;
            len_reg   <= '0;
            first_reg <= '0;
            last_reg  <= '0;
            pcur_reg  <= '0;
            cur_reg   <= '0;
            bit_reg   <= '0;
            total_reg <= '0;
            clean_reg <= 1'b0;
            dirty_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
            addr_reg  <= addr_next;
            len_reg   <= len_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            pcur_reg  <= pcur_next;
            cur_reg   <= cur_next;
            bit_reg   <= bit_next;
            total_reg <= total_next;
            clean_reg <= clean_next;
            dirty_reg <= dirty_next;
            done_reg  <= done_next;
        end
    end

    // Written-word map: one read and one write port at the shared row cursor.
    always_ff @(posedge clk)
    begin
        if (wmap_we)
        begin
            wmap_mem[wmap_addr] <= wmap_wdata;
        end
        wmap_q <= wmap_mem[wmap_addr];
    end

    // Dirty-page map.
    always_ff @(posedge clk)
    begin
        if (pmap_we)
        begin
            pmap_mem[pmap_addr] <= pmap_wdata;
        end
        pmap_q <= pmap_mem[pmap_addr];
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign dirty     = dirty_reg;
    assign run_bytes = total_reg[20:0];

endmodule

// ===== verif/tb_write_and_dirty_page_tracker_unit.sv =====
// Self-checking testbench for the write and dirty-page tracker unit.
module tb_write_and_dirty_page_tracker_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // Geometry of the instance under test.
    localparam int unsigned MEM_BYTES   = 1048576;
    localparam int unsigned PAGE_BYTES  = 4096;
    localparam int unsigned MWB         = wdpt_pkg::MAP_WORD_BITS;
    localparam int unsigned WORDS_TOTAL = MEM_BYTES / 4;
    localparam int unsigned WMAP_WORDS  = WORDS_TOTAL / MWB;
    localparam int unsigned PAGES_TOTAL = MEM_BYTES / PAGE_BYTES;
    localparam int unsigned PMAP_WORDS  = (PAGES_TOTAL + MWB - 1) / MWB;

    // Action codes the package leaves undefined; the block must answer them with zeros.
    localparam logic [2:0] ACT_SPARE_LO  = 3'd5;
    localparam logic [2:0] ACT_SPARE_MID = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI  = 3'd7;

    // Run length and guard rails.
    localparam int unsigned RANDOM_WORDS = 780;
    localparam int unsigned QUIET_FIRST  = 450;   // first word of the stretch with no gaps
    localparam int unsigned QUIET_LAST   = 650;
    localparam int unsigned FORCED_DRAIN = 300;   // word index where the sender waits for all results
    localparam int unsigned TAIL_CYCLES  = 200;
    // Longest word: a run over the whole written map, plus idle gaps.
    localparam int unsigned ITEM_WORST   = 2 * WMAP_WORDS + 16;
    localparam int unsigned CYCLE_LIMIT  = 4 * (RANDOM_WORDS + 40) * ITEM_WORST
                                         + WMAP_WORDS + TAIL_CYCLES;

    // One expected result word.
    typedef struct packed {
        logic        dirty;
        logic [20:0] run_bytes;
    } tracker_result_t;

    // Shadow copy of both bitmaps plus the queue of results still owed by the block.
    class dirty_page_scoreboard;
        bit [MWB-1:0]           written_words [WMAP_WORDS];
        bit [MWB-1:0]           dirty_pages [PMAP_WORDS];
        tracker_result_t        owed_q[$];
        int unsigned            errors;

        function int unsigned pending();
            return owed_q.size();
        endfunction

        // Return the pages a byte range touches; false when it touches none.
        function bit page_span(int unsigned addr, int unsigned len,
                               output int unsigned first_pg, output int unsigned last_pg);
            first_pg = addr / PAGE_BYTES;
            last_pg  = (addr + len - 1) / PAGE_BYTES;
            if (last_pg >= PAGES_TOTAL)
                last_pg = PAGES_TOTAL - 1;
            return (len != 0) && (addr < MEM_BYTES);
        endfunction

        function void clear_pages(int unsigned first_pg, int unsigned last_pg);
            for (int unsigned pg = first_pg; pg <= last_pg; pg++)
                dirty_pages[pg / MWB][pg % MWB] = 1'b0;
        endfunction

        // Update the shadow maps for an accepted command word and queue its result.
        function void note(logic [2:0] act, logic [19:0] addr, logic [20:0] len);
            tracker_result_t exp_r;
            int unsigned     w;
            int unsigned     first_pg;
            int unsigned     last_pg;
            int unsigned     total;
            bit              hit;
            exp_r = '0;
            case (wdpt_pkg::action_t'(act))
                wdpt_pkg::ACT_WRITE:
                begin
                    if (32'(addr) < MEM_BYTES)
                    begin
                        w = 32'(addr) >> 2;
                        written_words[w / MWB][w % MWB] = 1'b1;
                        first_pg = 32'(addr) / PAGE_BYTES;
                        dirty_pages[first_pg / MWB][first_pg % MWB] = 1'b1;
                    end
                end
                wdpt_pkg::ACT_CHECK, wdpt_pkg::ACT_CHECK_CLEAN:
                begin
                    if (page_span(32'(addr), 32'(len), first_pg, last_pg))
                    begin
                        hit = 1'b0;
                        for (int unsigned pg = first_pg; pg <= last_pg; pg++)
                            hit |= dirty_pages[pg / MWB][pg % MWB];
                        exp_r.dirty = hit;
                        if (hit && wdpt_pkg::action_t'(act) == wdpt_pkg::ACT_CHECK_CLEAN)
                            clear_pages(first_pg, last_pg);
                    end
                end
                wdpt_pkg::ACT_CLEAN:
                begin
                    if (page_span(32'(addr), 32'(len), first_pg, last_pg))
                        clear_pages(first_pg, last_pg);
                end
                wdpt_pkg::ACT_RUN:
                begin
                    total = 0;
                    if (32'(addr) < MEM_BYTES)
                        for (w = 32'(addr) >> 2;
                             w < WORDS_TOTAL && written_words[w / MWB][w % MWB];
                             w++)
                            total += 4;
                    exp_r.run_bytes = total[20:0];
                end
                default:
                    ;
            endcase
            owed_q.push_back(exp_r);
        endfunction

        task report(string what, logic [20:0] got, logic [20:0] want);
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
            errors++;
        endtask

        // Compare one result word against the oldest owed result.
        task check(logic got_dirty, logic [20:0] got_run);
            tracker_result_t exp_r;
            if (owed_q.size() == 0)
            begin
                report("result with nothing outstanding", got_run, '0);
                return;
            end
            exp_r = owed_q.pop_front();
            if (got_dirty !== exp_r.dirty)
                report("dirty", 21'(got_dirty), 21'(exp_r.dirty));
            if (got_run !== exp_r.run_bytes)
                report("run_bytes", got_run, exp_r.run_bytes);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  action;
    logic [19:0] address;
    logic [20:0] length_bytes;
    logic        done;
    logic        dirty;
    logic [20:0] run_bytes;

    int unsigned          cycle_count = 0;
    dirty_page_scoreboard sb = new();

    write_and_dirty_page_tracker_unit #(
        .MEM_BYTES  (MEM_BYTES),
        .PAGE_BYTES (PAGE_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .address      (address),
        .length_bytes (length_bytes),
        .done         (done),
        .dirty        (dirty),
        .run_bytes    (run_bytes)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Count cycles and abort a hung run.
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Result side: the block shows each result for one cycle only, so grab it at the edge.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check(dirty, run_bytes);
    end

    // Present one command word from a falling edge and hold it until the block takes it.
    // The shadow model advances at the accepting edge, in acceptance order.
    task automatic send_word(logic [2:0] act, logic [19:0] addr, logic [20:0] len);
        start        <= 1'b1;
        action       <= act;
        address      <= addr;
        length_bytes <= len;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note(act, addr, len);
        @(negedge clk);
    endtask

    // Drop start for a few cycles; scramble the idle fields so nothing leaks from them.
    task automatic hold_off(int unsigned cycles);
        start        <= 1'b0;
        action       <= 3'($urandom);
        address      <= 20'($urandom);
        length_bytes <= 21'($urandom);
        repeat (cycles) @(negedge clk);
    endtask

    // Drop start and wait until every owed result has come back.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    // Pick a range length: zero, short, page multiples, whole memory, or any 21-bit value.
    function automatic logic [20:0] pick_length();
        case ($urandom_range(9))
            0:       return '0;
            1, 2, 3: return 21'($urandom_range(64, 1));
            4, 5:    return 21'($urandom_range(8192, 1));
            6:       return 21'($urandom_range(256, 1) * PAGE_BYTES);
            7:       return 21'(MEM_BYTES);
            default: return 21'($urandom);
        endcase
    endfunction

    initial
    begin
        int unsigned stream_addr;
        int unsigned stream_base;
        int unsigned stream_left;
        int unsigned r;
        logic [19:0] a_addr;
        logic [2:0]  a_act;

        stream_addr  = 0;
        stream_base  = 0;
        stream_left  = 0;

        // Hold every input at a known value through reset.
        rst_n        = 1'b0;
        start        = 1'b0;
        action       = wdpt_pkg::ACT_WRITE;
        address      = '0;
        length_bytes = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // The clearing pass keeps busy high; send_word simply waits it out.

        // Directed part: empty maps first, then edges of memory, unaligned
        // addresses, zero lengths, ranges running off the end, and spare codes.
        send_word(wdpt_pkg::ACT_RUN,         20'h00000, 21'd0);
        send_word(wdpt_pkg::ACT_CHECK,       20'h00000, 21'h100000);
        send_word(wdpt_pkg::ACT_WRITE,       20'h00000, 21'h1FFFFF);
        send_word(wdpt_pkg::ACT_WRITE,       20'h00005, 21'd0);        // unaligned: word 1
        send_word(wdpt_pkg::ACT_WRITE,       20'hFFFFC, 21'd0);        // last word of memory
        send_word(wdpt_pkg::ACT_WRITE,       20'hFFFFB, 21'd0);        // unaligned, next to last
        send_word(wdpt_pkg::ACT_RUN,         20'h00002, 21'h1FFFFF);   // unaligned run start
        send_word(wdpt_pkg::ACT_RUN,         20'hFFFF9, 21'd0);        // run stops at the end
        send_word(wdpt_pkg::ACT_RUN,         20'hFFFFF, 21'd0);
        send_word(wdpt_pkg::ACT_CHECK,       20'h00000, 21'd0);        // zero length is clean
        send_word(wdpt_pkg::ACT_CHECK,       20'h01000, 21'h001000);   // clean page only
        send_word(wdpt_pkg::ACT_CHECK,       20'hFFFFF, 21'h1FFFFF);   // past the end: last page
        send_word(wdpt_pkg::ACT_CHECK_CLEAN, 20'h00800, 21'h001000);   // dirty, pages cleared
        send_word(wdpt_pkg::ACT_CHECK,       20'h00000, 21'd1);
        send_word(wdpt_pkg::ACT_CHECK_CLEAN, 20'h01000, 21'd4);        // clean: nothing changes
        send_word(wdpt_pkg::ACT_CLEAN,       20'hFF000, 21'h1FFFFF);   // clean always reports 0
        send_word(wdpt_pkg::ACT_CHECK,       20'h00000, 21'h100000);
        send_word(wdpt_pkg::ACT_WRITE,       20'h03000, 21'd0);
        send_word(wdpt_pkg::ACT_CLEAN,       20'h03000, 21'd0);        // zero length is a no-op
        send_word(wdpt_pkg::ACT_CHECK,       20'h03FFF, 21'd1);
        send_word(wdpt_pkg::ACT_RUN,         20'h00000, 21'd0);        // written bits survive
        send_word(ACT_SPARE_LO,              20'hFFFFF, 21'h1FFFFF);
        send_word(ACT_SPARE_MID,             20'h03000, 21'h001000);
        send_word(ACT_SPARE_HI,              20'h00000, 21'd0);

        // Random part: mostly streams of consecutive word writes so that runs and
        // dirty pages build up, mixed with range queries and runs aimed at them.
        for (int unsigned i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == FORCED_DRAIN)
                drain_results();
            else if ((i < QUIET_FIRST || i >= QUIET_LAST) && $urandom_range(99) < 14)
                hold_off($urandom_range(8, 1));
            else if ((i < QUIET_FIRST || i >= QUIET_LAST) && $urandom_range(199) == 0)
                drain_results();

            r = $urandom_range(99);
            if (r < 60)
            begin
                if (stream_left == 0)
                begin
                    case ($urandom_range(3))
                        0:       stream_addr = $urandom_range(MEM_BYTES - 4) & ~32'd3;
                        1:       stream_addr = $urandom_range(32'hFFFF) & ~32'd3;
                        2:       stream_addr = (32'hF0000 + $urandom_range(32'hFFFF)) & ~32'd3;
                        default: stream_addr = MEM_BYTES - 4 * $urandom_range(80, 1);
                    endcase
                    stream_base = stream_addr;
                    stream_left = $urandom_range(80, 4);
                end
                if ($urandom_range(6) == 0)
                    a_addr = 20'($urandom);            // stray write anywhere
                else
                begin
                    // Advance the stream; now and then use a byte address inside the word.
                    a_addr = 20'(stream_addr + (($urandom_range(7) == 0) ? $urandom_range(3) : 0));
                    stream_addr += 4;
                    stream_left--;
                    if (stream_addr >= MEM_BYTES)
                        stream_left = 0;
                end
                send_word(wdpt_pkg::ACT_WRITE, a_addr, 21'($urandom));
            end
            else if (r < 84)
            begin
                a_act = (r < 70) ? wdpt_pkg::ACT_CHECK
                      : (r < 78) ? wdpt_pkg::ACT_CHECK_CLEAN : wdpt_pkg::ACT_CLEAN;
                a_addr = $urandom_range(1) ? 20'(stream_base + $urandom_range(8191))
                                           : 20'($urandom);
                send_word(a_act, a_addr, pick_length());
            end
            else if (r < 97)
            begin
                a_addr = ($urandom_range(9) < 6)
                       ? 20'(stream_base + 4 * $urandom_range(120) + $urandom_range(3))
                       : 20'($urandom);
                send_word(wdpt_pkg::ACT_RUN, a_addr, 21'($urandom));
            end
            else
                send_word(3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO)), 20'($urandom),
                          21'($urandom));
        end

        // Wind down: stop sending, collect what is owed, then watch for stray results.
        hold_off(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/wdpt_pkg.sv
rtl/core/wdpt_bit_eval.sv
rtl/core/write_and_dirty_page_tracker_unit.sv
verif/tb_write_and_dirty_page_tracker_unit.sv
